/* src/slip_pkg.sv */
// Shared types and constants for the SLIP frame encoder.
`timescale 1ns / 1ps
package slip_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_START_BYTE  = 2'd0,
		REG_END_BYTE    = 2'd1,
		REG_ESCAPE_BYTE = 2'd2,
		REG_ESCAPE_MASK = 2'd3
	} reg_idx_t;

	// Reset values of the special bytes
	localparam logic [7:0] START_BYTE_RST  = 8'd192;
	localparam logic [7:0] END_BYTE_RST    = 8'd192;
	localparam logic [7:0] ESCAPE_BYTE_RST = 8'd219;
	localparam logic [7:0] ESCAPE_MASK_RST = 8'd32;

	// Most line bytes one input beat can produce
	localparam int unsigned MAX_RUN = 4;
	localparam int unsigned RUN_IW  = $clog2(MAX_RUN);

	// Queue depth between classifier and emitter
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	// One classified input beat: its line bytes in order
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_IW-1:0]       last_idx;
		logic                    done;
	} run_t;

endpackage

/* src/slip_front.sv */
// Front end: configuration registers and classification of each input beat.
`timescale 1ns / 1ps
module slip_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [7:0]           cfg_data,
	input  logic [7:0]           payload_byte,
	input  logic                 frame_first,
	input  logic                 frame_last,
	input  logic                 empty_frame,
	output slip_pkg::run_t       run
);
	import slip_pkg::*;

	logic [7:0] start_q, end_q, escape_q, mask_q;
	logic       esc;
	logic [RUN_IW:0] pos;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_BYTE_RST;
			end_q    <= END_BYTE_RST;
			escape_q <= ESCAPE_BYTE_RST;
			mask_q   <= ESCAPE_MASK_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_START_BYTE:  start_q  <= cfg_data;
				REG_END_BYTE:    end_q    <= cfg_data;
				REG_ESCAPE_BYTE: escape_q <= cfg_data;
				REG_ESCAPE_MASK: mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload hits any special byte -> needs escaping
	assign esc = (payload_byte == start_q) || (payload_byte == end_q) ||
		(payload_byte == escape_q);

	// Lay out the run of line bytes for this beat
	always_comb begin
		run.bytes = '0;
		pos       = '0;
		if (empty_frame) begin
			run.bytes[0] = start_q;
			run.bytes[1] = end_q;
			pos          = (RUN_IW+1)'(2);
			run.done     = 1'b1;
		end else begin
			if (frame_first) begin
				run.bytes[0] = start_q;
				pos          = pos + 1'b1;
			end
			if (esc) begin
				run.bytes[pos[RUN_IW-1:0]]        = escape_q;
				run.bytes[pos[RUN_IW-1:0] + 1'b1] = payload_byte ^ mask_q;
				pos                               = pos + (RUN_IW+1)'(2);
			end else begin
				run.bytes[pos[RUN_IW-1:0]] = payload_byte;
				pos                        = pos + 1'b1;
			end
			if (frame_last) begin
				run.bytes[pos[RUN_IW-1:0]] = end_q;
				pos                        = pos + 1'b1;
			end
			run.done = frame_last;
		end
		run.last_idx = RUN_IW'(pos - 1'b1);
	end

endmodule

/* src/slip_queue.sv */
// Short queue of classified runs between front end and emitter.
`timescale 1ns / 1ps
module slip_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slip_pkg::run_t push_run,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output slip_pkg::run_t head_run
);
	import slip_pkg::*;

	run_t             mem [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]  cnt_q;

	assign full       = (cnt_q == Q_CW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_run   = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_run;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* src/slip_back.sv */
// Emitter: walks each queued run and drives one line byte per beat.
`timescale 1ns / 1ps
module slip_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  slip_pkg::run_t head_run,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);
	import slip_pkg::*;

	logic [RUN_IW-1:0] idx_q;
	logic              load, at_end;
	logic              valid_q, last_q, done_q;
	logic [7:0]        data_q;

	assign load   = head_valid && (!valid_q || m_tready);
	assign at_end = (idx_q == head_run.last_idx);
	assign pop    = load && at_end;

	// Position inside the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head_run.bytes[idx_q];
			last_q <= at_end;
			done_q <= at_end && head_run.done;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

`ifndef SYNTH
	// Frame end byte is always the last byte of its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end flagged on a byte that is not last of its run");

	// Run position never passes the run length
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head_run.last_idx)
		else $error("run position beyond last byte");

	// No run in progress when the queue is empty
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == '0)
		else $error("run position nonzero with empty queue");

	// Popping a run restarts the position
	a_pop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("position not cleared after a run");
`endif

endmodule

/* src/slip_frame_encoder.sv */
// Top level of the SLIP frame encoder.
// Encodes one payload beat per accepted input into one to four line bytes:
// start byte ahead of a first byte, escape byte plus masked byte for a
// payload equal to any special byte, end byte after a last byte. The output
// runs at one line byte per cycle while m_tready allows, set by the output
// register. A two-entry queue of classified beats lets input accept while
// earlier bytes still drain, so input is back-pressured only when two beats
// wait. Config writes take effect on the next accepted beat and are meant
// to occur while idle. An empty frame beat gives only start and end byte.
`timescale 1ns / 1ps
module slip_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] payload_byte
	input  logic       s_tlast,   // frame_last
	input  logic [1:0] s_tuser,   // [0] frame_first, [1] empty_frame
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] line_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // [0] frame_done
);
	import slip_pkg::*;

	run_t in_run, head_run;
	logic full, push, pop, head_valid;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	slip_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.payload_byte (s_tdata),
		.frame_first  (s_tuser[0]),
		.frame_last   (s_tlast),
		.empty_frame  (s_tuser[1]),
		.run          (in_run)
	);

	slip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (in_run),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_run   (head_run)
	);

	slip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_run   (head_run),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

/* test/slip_line_checker.sv */
// Checker for the SLIP frame encoder: predicts the line bytes of each input beat and compares.
`timescale 1ns / 1ps
module slip_line_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [7:0]        cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] payload_byte
	input  logic              s_tlast,   // frame_last
	input  logic [1:0]        s_tuser,   // [0] frame_first, [1] empty_frame
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,   // [7:0] line_byte
	input  logic              m_tlast,   // run_last
	input  logic              m_tuser,   // [0] frame_done
	output int unsigned       lines_pending,
	output int unsigned       mismatch_count
);
	import slip_pkg::*;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_done;
	} line_beat_t;

	// shadow copy of the special bytes
	logic [7:0] start_byte;
	logic [7:0] end_byte;
	logic [7:0] escape_byte;
	logic [7:0] escape_mask;

	line_beat_t  expected_lines[$];
	int unsigned fail_total;

	// queue the line bytes one input beat should produce
	task automatic queue_encoded_beat(input logic [7:0] payload, input logic first,
			input logic last, input logic empty);
		line_beat_t run[MAX_RUN];
		int n;
		n = 0;
		if (empty) begin
			run[n] = '{start_byte, 1'b0, 1'b0}; n++;
			run[n] = '{end_byte, 1'b0, 1'b1}; n++;
		end else begin
			if (first) begin
				run[n] = '{start_byte, 1'b0, 1'b0}; n++;
			end
			// every special byte is checked, even when some are equal
			if (payload == start_byte || payload == end_byte || payload == escape_byte) begin
				run[n] = '{escape_byte, 1'b0, 1'b0}; n++;
				run[n] = '{payload ^ escape_mask, 1'b0, 1'b0}; n++;
			end else begin
				run[n] = '{payload, 1'b0, 1'b0}; n++;
			end
			if (last) begin
				run[n] = '{end_byte, 1'b0, 1'b1}; n++;
			end
		end
		run[n-1].run_last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_lines.insert(expected_lines.size(), run[k]);
	endtask

	// output beats are checked before the same edge's input beat is predicted;
	// a beat cannot leave on the edge it enters
	always @(posedge clk or negedge arst_n) begin
		line_beat_t want;
		line_beat_t got;
		if (!arst_n) begin
			start_byte = START_BYTE_RST;
			end_byte = END_BYTE_RST;
			escape_byte = ESCAPE_BYTE_RST;
			escape_mask = ESCAPE_MASK_RST;
			expected_lines.delete();
			fail_total = 0;
			lines_pending <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_START_BYTE:  start_byte = cfg_data;
					REG_END_BYTE:    end_byte = cfg_data;
					REG_ESCAPE_BYTE: escape_byte = cfg_data;
					REG_ESCAPE_MASK: escape_mask = cfg_data;
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tlast, m_tuser};
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected line beat: expected none, actual %02h last %b done %b",
						$time, got.line_byte, got.run_last, got.frame_done);
					fail_total++;
				end else begin
					want = expected_lines.pop_front();
					if (got.line_byte !== want.line_byte) begin
						$display("%0t: line_byte expected %02h actual %02h",
							$time, want.line_byte, got.line_byte);
						fail_total++;
					end
					if (got.run_last !== want.run_last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, want.run_last, got.run_last);
						fail_total++;
					end
					if (got.frame_done !== want.frame_done) begin
						$display("%0t: frame_done expected %b actual %b",
							$time, want.frame_done, got.frame_done);
						fail_total++;
					end
				end
			end

			if (s_tvalid && s_tready)
				queue_encoded_beat(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);

			lines_pending <= expected_lines.size();
			mismatch_count <= fail_total;
		end
	end

endmodule

/* test/slip_frame_encoder_tb.sv */
// Top of the SLIP frame encoder testbench: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module slip_frame_encoder_tb;
	import slip_pkg::*;

	localparam int unsigned STALL_LIMIT     = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 75;
	localparam int unsigned NUM_PHASES      = 6;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] payload_byte
	logic       s_tlast;   // frame_last
	logic [1:0] s_tuser;   // [0] frame_first, [1] empty_frame
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] line_byte
	logic       m_tlast;   // run_last
	logic       m_tuser;   // [0] frame_done

	int unsigned lines_pending;
	int unsigned mismatch_count;
	int unsigned stall_cycles;
	int unsigned src_idle_pct;
	int unsigned dst_idle_pct;

	// current special bytes, used only to aim payloads at them
	logic [7:0] cur_start;
	logic [7:0] cur_end;
	logic [7:0] cur_escape;

	slip_frame_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	slip_line_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.lines_pending(lines_pending), .mismatch_count(mismatch_count)
	);

	always #10 clk = ~clk;

	// line side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// one payload beat, after a random number of idle cycles
	task automatic send_item(input logic [7:0] payload, input logic first,
			input logic last, input logic empty);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= payload;
		s_tlast <= last;
		s_tuser <= {empty, first};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the input until every line byte is out, then let the pipe settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (lines_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] sb, input logic [7:0] eb,
			input logic [7:0] xb, input logic [7:0] mask);
		wait_drained();
		write_reg(REG_START_BYTE, sb);
		write_reg(REG_END_BYTE, eb);
		write_reg(REG_ESCAPE_BYTE, xb);
		write_reg(REG_ESCAPE_MASK, mask);
		cfg_we <= 1'b0;
		cur_start = sb;
		cur_end = eb;
		cur_escape = xb;
	endtask

	// payloads lean on the special bytes and the extremes
	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(99);
		if (r < 10) return cur_start;
		if (r < 20) return cur_end;
		if (r < 30) return cur_escape;
		if (r < 34) return 8'h00;
		if (r < 38) return 8'hFF;
		return 8'($urandom);
	endfunction

	// mostly well-formed frames, some empty frames and loose marks
	task automatic send_random_frames(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
				sent++;
			end else if (r < 22) begin
				send_item(pick_payload(), 1'($urandom), 1'($urandom), 1'b0);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_item(pick_payload(), k == 0, k == len - 1, 1'b0);
				sent += len;
			end
		end
	endtask

	initial begin
		logic [7:0] sb;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_START_BYTE;
		cfg_data <= 8'h00;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		s_tuser <= 2'b00;
		cur_start = START_BYTE_RST;
		cur_end = END_BYTE_RST;
		cur_escape = ESCAPE_BYTE_RST;
		src_idle_pct = 18;
		dst_idle_pct = 46;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset settings
		send_item(8'hAA, 1'b0, 1'b0, 1'b1);   // empty frame, marks clear
		send_item(8'hC0, 1'b1, 1'b1, 1'b1);   // empty frame, marks set, payload special
		send_item(8'hDB, 1'b1, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0, 1'b0);   // opening beat
		send_item(8'hFF, 1'b0, 1'b0, 1'b0);   // middle beat
		send_item(8'hC0, 1'b0, 1'b0, 1'b0);   // start/end byte escaped
		send_item(8'hDB, 1'b0, 1'b0, 1'b0);   // escape byte escaped
		send_item(8'h20, 1'b0, 1'b1, 1'b0);   // closing beat
		send_item(8'hC0, 1'b1, 1'b1, 1'b0);   // longest run
		send_item(8'hDB, 1'b1, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b1, 1'b0);
		send_item(8'hE0, 1'b0, 1'b0, 1'b0);   // masked value is not special
		send_item(8'hFB, 1'b0, 1'b0, 1'b0);
		send_item(8'hDB, 1'b1, 1'b0, 1'b0);
		send_item(8'hC0, 1'b0, 1'b1, 1'b0);
		send_item(8'h01, 1'b0, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0, 1'b0);
		send_item(8'h7F, 1'b0, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1, 1'b1);
		// sender waits for the line to drain before going on
		wait_drained();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				1: apply_config(8'h00, 8'hFF, 8'h00, 8'hFF);
				2: apply_config(8'hFF, 8'hFF, 8'hFF, 8'h00);
				3: apply_config(8'h7E, 8'h7E, 8'h7D, 8'h20);
				4: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				5: begin
					sb = 8'($urandom);
					apply_config(sb, sb, 8'($urandom), 8'($urandom));
				end
				default: ;
			endcase
			if (phase >= 4) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end else if (phase >= 2) begin
				src_idle_pct = 46;
				dst_idle_pct = 18;
			end
			send_random_frames(ITEMS_PER_PHASE);
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
